FILE: sv/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
// No dependencies.
package stq_pkg;
  localparam int unsigned TIMER_SLOTS = 16;
  localparam int unsigned SLOT_W = $clog2(TIMER_SLOTS);
  localparam int unsigned CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned ENTRY_W = 72;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_IDLE_TICK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NULL_TAG = 2'd1;
  localparam logic [1:0] ST_ZERO_INT = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [63:0] NEVER = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage

FILE: sv/stq_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with a registered read.
// No dependencies.
module stq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: sv/stq_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on stq_pkg.
module stq_div
  import stq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [31:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[15:0], quo_q[31]};
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      dsr_d = req_i.divisor;
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

FILE: sv/sorted_timer_queue_unit.sv
// Top level of the sorted timer queue: control sequencer and slot memory.
// Depends on stq_pkg, stq_ram and stq_div.
//
// channel | handshake         | payload
// in      | in_valid/ready    | operation, delay_ms, callback_tag
// out     | out_valid/ready   | kind, status, expired_tag, now_tick, next_fire_tick,
//         |                   | pending_count, last
// cfg     | APB write/read    | tick_period_ms at address 0
//
// A request is divided, then the table is scanned (read, check) for its slot,
// later slots are shifted (read, write), the entry is inserted and the result is
// loaded; a rejected request goes straight to the result register.
// A tick reads and checks slots in turn, reads and emits each expired result, which
// the output can stall, and compacts the remaining slots after the last result.
// The input is held off while an item is in work or its last result waits.
// Reset empties the table; no clearing pass.
module sorted_timer_queue_unit
  import stq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] delay_ms_i,
  input  logic [7:0]  callback_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [7:0]  expired_tag_o,
  output logic [63:0] now_tick_o,
  output logic [63:0] next_fire_tick_o,
  output logic [4:0]  pending_count_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD, S_SHIFT_WR, S_INS,
    S_TICK_RD, S_TICK_CHK, S_EMIT_RD, S_EMIT, S_CMP_RD, S_CMP_WR, S_RESP
  } state_e;

  state_e state_q;
  logic [15:0] period_q;
  logic [63:0] tick_q, next_q, expiry_q;
  logic [CNT_W-1:0] occ_q;
  logic [CNT_W-1:0] pos_q, idx_q, drop_q;
  logic [7:0] tag_q;
  logic       ov_q;
  logic [1:0] kind_q, status_q;
  logic [7:0] etag_q;
  logic       last_q;

  logic              we;
  logic [SLOT_W-1:0] waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic [63:0] r_exp;
  logic [7:0]  r_tag;

  logic in_fire, out_fire, out_load, cfg_wr;
  logic [63:0] fire_dist;
  logic [63:0] fire_val;

  div_req_t dreq;
  div_rsp_t drsp;

  stq_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMER_SLOTS)) u_slots (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  stq_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign r_exp = rdata[71:8];
  assign r_tag = rdata[7:0];

  assign in_ready_o = (state_q == S_IDLE) && !ov_q;
  assign in_fire = in_valid_i && in_ready_o;
  assign out_fire = ov_q && out_ready_i;
  assign out_load = ((state_q == S_RESP) || (state_q == S_EMIT)) && (!ov_q || out_fire);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, period_q} : 32'd0;

  always_comb begin
    fire_dist = r_exp - tick_q;
    fire_val = (fire_dist == 64'd0) ? tick_q + 64'd1 : r_exp;
  end

  always_comb begin
    dreq.start = in_fire && (operation_i == OP_REQUEST) && (callback_tag_i != 8'd0)
                 && (delay_ms_i != 32'd0) && (occ_q < CNT_W'(TIMER_SLOTS));
    dreq.dividend = delay_ms_i;
    dreq.divisor = period_q;
  end

  always_comb begin
    we = 1'b0;
    waddr = idx_q[SLOT_W-1:0];
    wdata = rdata;
    raddr = idx_q[SLOT_W-1:0];
    case (state_q)
      S_SHIFT_RD: raddr = SLOT_W'(idx_q - CNT_W'(1));
      S_SHIFT_WR: we = 1'b1;
      S_INS: begin
        we = 1'b1;
        waddr = pos_q[SLOT_W-1:0];
        wdata = {expiry_q, tag_q};
      end
      S_CMP_RD: raddr = SLOT_W'(idx_q + drop_q);
      S_CMP_WR: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      period_q <= 16'd1;
      tick_q <= '0;
      next_q <= NEVER;
      occ_q <= '0;
      ov_q <= 1'b0;
      pos_q <= '0;
      idx_q <= '0;
      drop_q <= '0;
      tag_q <= '0;
      expiry_q <= '0;
      kind_q <= KIND_STATUS;
      status_q <= ST_OK;
      etag_q <= '0;
      last_q <= 1'b0;
    end else begin
      if (cfg_wr && paddr == 2'd0) begin
        period_q <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_fire) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            tag_q <= callback_tag_i;
            etag_q <= '0;
            last_q <= 1'b1;
            if (operation_i == OP_TICK) begin
              status_q <= ST_OK;
              tick_q <= tick_q + 64'd1;
              idx_q <= '0;
              drop_q <= '0;
              if (occ_q == '0) begin
                next_q <= NEVER;
                kind_q <= KIND_IDLE_TICK;
                state_q <= S_RESP;
              end else begin
                state_q <= S_TICK_RD;
              end
            end else begin
              kind_q <= KIND_STATUS;
              if (callback_tag_i == 8'd0) begin
                status_q <= ST_NULL_TAG;
                state_q <= S_RESP;
              end else if (delay_ms_i == 32'd0) begin
                status_q <= ST_ZERO_INT;
                state_q <= S_RESP;
              end else if (occ_q >= CNT_W'(TIMER_SLOTS)) begin
                status_q <= ST_FULL;
                state_q <= S_RESP;
              end else begin
                status_q <= ST_OK;
                state_q <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            expiry_q <= tick_q + ((drsp.quotient == 32'd0) ? 64'd1
                                                           : {32'd0, drsp.quotient});
            pos_q <= '0;
            idx_q <= '0;
            state_q <= (occ_q == '0) ? S_INS : S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (r_exp <= expiry_q) begin
            pos_q <= idx_q + CNT_W'(1);
            idx_q <= idx_q + CNT_W'(1);
            state_q <= (idx_q + CNT_W'(1) >= occ_q) ? S_INS : S_SCAN_RD;
          end else begin
            idx_q <= occ_q;
            state_q <= S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: state_q <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          idx_q <= idx_q - CNT_W'(1);
          state_q <= (idx_q - CNT_W'(1) == pos_q) ? S_INS : S_SHIFT_RD;
        end
        S_INS: begin
          occ_q <= occ_q + CNT_W'(1);
          if (pos_q == '0) begin
            next_q <= (expiry_q == tick_q) ? tick_q + 64'd1 : expiry_q;
          end
          state_q <= S_RESP;
        end
        S_TICK_RD: state_q <= S_TICK_CHK;
        S_TICK_CHK: begin
          if (r_exp <= tick_q) begin
            if (idx_q + CNT_W'(1) >= occ_q) begin
              drop_q <= idx_q + CNT_W'(1);
              occ_q <= '0;
              next_q <= NEVER;
              idx_q <= '0;
              state_q <= S_EMIT_RD;
            end else begin
              idx_q <= idx_q + CNT_W'(1);
              state_q <= S_TICK_RD;
            end
          end else begin
            drop_q <= idx_q;
            occ_q <= occ_q - idx_q;
            next_q <= fire_val;
            idx_q <= '0;
            if (idx_q == '0) begin
              kind_q <= KIND_IDLE_TICK;
              state_q <= S_RESP;
            end else begin
              state_q <= S_EMIT_RD;
            end
          end
        end
        S_EMIT_RD: state_q <= S_EMIT;
        S_EMIT: begin
          if (out_load) begin
            kind_q <= KIND_EXPIRED;
            etag_q <= r_tag;
            if (idx_q + CNT_W'(1) == drop_q) begin
              last_q <= 1'b1;
              idx_q <= '0;
              state_q <= (occ_q == '0) ? S_IDLE : S_CMP_RD;
            end else begin
              last_q <= 1'b0;
              idx_q <= idx_q + CNT_W'(1);
              state_q <= S_EMIT_RD;
            end
          end
        end
        S_CMP_RD: state_q <= S_CMP_WR;
        S_CMP_WR: begin
          idx_q <= idx_q + CNT_W'(1);
          state_q <= (idx_q + CNT_W'(1) >= occ_q) ? S_IDLE : S_CMP_RD;
        end
        S_RESP: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o = kind_q;
  assign status_o = status_q;
  assign expired_tag_o = etag_q;
  assign now_tick_o = tick_q;
  assign next_fire_tick_o = next_q;
  assign pending_count_o = 5'(occ_q);
  assign last_o = last_q;
endmodule
